[hw/rtl/assert_macros.svh]
// Assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[hw/rtl/lzbd_pkg.sv]
package lzbd_pkg;
  localparam logic [2:0] PH_LIT  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_LENX = 3'd2;
  localparam logic [2:0] PH_LENB = 3'd3;
  localparam logic [2:0] PH_RUN  = 3'd4;
  localparam logic [2:0] PH_DIST = 3'd5;
  localparam logic [2:0] PH_COPY = 3'd6;
  localparam logic [2:0] PH_ERR  = 3'd7;

  localparam logic CMD_DELIVER = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [2:0] REG_OUT_LEN  = 3'd0;
  localparam logic [2:0] REG_FIRST    = 3'd1;
  localparam logic [2:0] REG_SEED     = 3'd2;
  localparam logic [2:0] REG_PAD      = 3'd3;
  localparam logic [2:0] REG_BASE_LO  = 3'd4;
  localparam logic [2:0] REG_BASE_HI  = 3'd5;
  localparam logic [2:0] REG_DBITS    = 3'd6;

  localparam logic [7:0] LEN_BIAS = 8'd6;

  typedef struct packed {
    logic       start;
    logic       mem_wait;
  } ctl_cmd_t;

  typedef struct packed {
    logic       need_read;
  } ctl_sts_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [31:0] out_position;
    logic        need_byte;
    logic        byte_taken;
    logic        finished;
    logic        distance_error;
  } result_t;

  function automatic logic [3:0] run_extra(input logic [3:0] i);
    case (i)
      4'd0, 4'd1, 4'd2, 4'd3: run_extra = 4'd1;
      4'd4: run_extra = 4'd2;
      4'd5, 4'd6: run_extra = 4'd3;
      4'd7, 4'd8: run_extra = 4'd4;
      4'd9: run_extra = 4'd5;
      4'd10: run_extra = 4'd7;
      4'd11: run_extra = 4'd14;
      default: run_extra = 4'd0;
    endcase
  endfunction

  function automatic logic [4:0] run_far_base(input logic [1:0] i);
    case (i)
      2'd0: run_far_base = 5'd6;
      2'd1: run_far_base = 5'd10;
      2'd2: run_far_base = 5'd10;
      default: run_far_base = 5'd18;
    endcase
  endfunction
endpackage

[hw/rtl/lzbd_ram.sv]
module lzbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/lzbd_ctrl.sv]
module lzbd_ctrl import lzbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  logic     out_fire_i,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o,
  output logic     in_ready_o,
  output logic     out_valid_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.start = 1'b0;
    cmd_o.mem_wait = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.start = 1'b1;
          state_d = sts_i.need_read ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        cmd_o.mem_wait = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_fire_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`include "assert_macros.svh"
  `ASSERT_NEXT(a_read_then_out, clk_i, rst_ni, state_q == S_READ, state_q == S_OUT)
  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE, !in_ready_o)
  `ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_o && !out_fire_i, out_valid_o)
endmodule

[hw/rtl/lzbd_datapath.sv]
module lzbd_datapath import lzbd_pkg::*; #(
  parameter int WINDOW_BYTES = 131072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_cmd_t    cmd_i,
  output ctl_sts_t    sts_o,
  input  logic        cmd_bit_i,
  input  logic [7:0]  cbyte_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic [63:0] cfg_rdata_o,
  output result_t     res_o
);
  localparam int AW = $clog2(WINDOW_BYTES);

  logic [31:0] out_len_q, first_q;
  logic [7:0]  seed_q;
  logic        skip_q;
  logic [63:0] blo_q, bhi_q;
  logic [59:0] dbits_q;

  logic [7:0]  bb_q, bb_d, hb_q, hb_d;
  logic        hf_q, hf_d, pad_q, pad_d;
  logic [31:0] wp_q, wp_d, lit_q, lit_d;
  logic [7:0]  cl_q, cl_d;
  logic [19:0] cd_q, cd_d;
  logic [1:0]  lc_q, lc_d;
  logic [2:0]  ph_q, ph_d;
  logic [1:0]  fs_q, fs_d, fc_q, fc_d;
  logic [4:0]  fb_q, fb_d;
  logic [31:0] fv_q, fv_d;
  result_t     res_q, res_d;
  logic        copy_pend_q;

  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  lzbd_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_hist (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [31:0] wp_m1;
  logic [31:0] rsum;
  assign wp_m1 = wp_q - 32'd1;
  assign rsum = wp_q + {12'd0, cd_q};
  assign raddr = rsum[AW-1:0];

  logic in_lit0, in_copy0, len_entry, stall_adv;
  always_comb begin
    in_lit0 = (ph_q == PH_LIT) && (lit_q == 32'd0);
    in_copy0 = (ph_q == PH_COPY) && (cl_q == 8'd0);
    len_entry = in_lit0 || (in_copy0 && (lit_q == 32'd0));
    stall_adv = (ph_q == PH_ERR) || (wp_q == 32'd0);
    sts_o.need_read = cmd_bit_i && !stall_adv && (ph_q == PH_COPY) && (cl_q != 8'd0);
  end

  always_comb begin
    case (cfg_idx_i)
      REG_OUT_LEN: cfg_rdata_o = {32'd0, out_len_q};
      REG_FIRST:   cfg_rdata_o = {32'd0, first_q};
      REG_SEED:    cfg_rdata_o = {56'd0, seed_q};
      REG_PAD:     cfg_rdata_o = {63'd0, skip_q};
      REG_BASE_LO: cfg_rdata_o = blo_q;
      REG_BASE_HI: cfg_rdata_o = bhi_q;
      REG_DBITS:   cfg_rdata_o = {4'd0, dbits_q};
      default:     cfg_rdata_o = 64'd0;
    endcase
  end

  logic        bit_ok, bitv;
  logic [3:0]  widx;
  logic [4:0]  fwidth;
  logic [15:0] dbase;
  logic [32:0] dsum;
  logic [32:0] dend;
  logic [31:0] nval;
  logic        vdone;
  logic [1:0]  ocls;
  logic [5:0]  widx6;

  always_comb begin
    bb_d = bb_q; hb_d = hb_q; hf_d = hf_q; pad_d = pad_q;
    wp_d = wp_q; lit_d = lit_q; cl_d = cl_q; cd_d = cd_q; lc_d = lc_q;
    ph_d = ph_q; fs_d = fs_q; fc_d = fc_q; fb_d = fb_q; fv_d = fv_q;
    res_d = res_q;
    we = 1'b0; waddr = wp_m1[AW-1:0]; wdata = hb_q;
    bit_ok = 1'b0; bitv = 1'b0; widx = 4'd0; fwidth = 5'd0; dbase = 16'd0;
    dsum = 33'd0; dend = 33'd0; nval = 32'd0; vdone = 1'b0; ocls = 2'd0; widx6 = 6'd0;

    if (cmd_i.mem_wait) begin
      wp_d = wp_m1;
      cl_d = cl_q - 8'd1;
      we = 1'b1; wdata = rdata;
      res_d.out_valid = 1'b1; res_d.out_byte = rdata; res_d.out_position = wp_m1;
      res_d.finished = (wp_m1 == 32'd0);
    end else if (cmd_i.start) begin
      res_d = '0;
      if (cmd_bit_i == CMD_DELIVER) begin
        if (pad_q) begin
          pad_d = 1'b0; res_d.byte_taken = 1'b1;
        end else if (!hf_q) begin
          hb_d = cbyte_i; hf_d = 1'b1; res_d.byte_taken = 1'b1;
        end
      end else if (!stall_adv) begin
        if ((ph_q == PH_LIT && !in_lit0) || (in_copy0 && !len_entry)) begin
          if (in_copy0) ph_d = PH_LIT;
          if (!hf_q) res_d.need_byte = 1'b1;
          else begin
            hf_d = 1'b0; lit_d = lit_q - 32'd1; wp_d = wp_m1; we = 1'b1;
            res_d.out_valid = 1'b1; res_d.out_byte = hb_q; res_d.out_position = wp_m1;
          end
        end else if (ph_q == PH_COPY && !len_entry) begin
          // Byte is written after the history read returns.
        end else if (ph_q == PH_LENB) begin
          if (!hf_q) res_d.need_byte = 1'b1;
          else begin
            hf_d = 1'b0; cl_d = hb_q; ph_d = PH_RUN;
            fs_d = 2'd0; fc_d = 2'd0; fb_d = 5'd0; fv_d = 32'd0;
          end
        end else begin
          if (len_entry) begin
            ph_d = PH_LEN; fs_d = 2'd0; fc_d = 2'd0; fb_d = 5'd0; fv_d = 32'd0;
          end
          if (bb_q[6:0] == 7'd0) begin
            if (hf_q) begin
              bit_ok = 1'b1; bitv = hb_q[7]; bb_d = {hb_q[6:0], bb_q[7]}; hf_d = 1'b0;
            end else res_d.need_byte = 1'b1;
          end else begin
            bit_ok = 1'b1; bitv = bb_q[7]; bb_d = {bb_q[6:0], 1'b0};
          end
          if (bit_ok) begin
            if (ph_q == PH_LEN || len_entry) begin
              if (len_entry || fb_q < 5'd4) begin
                if (bitv) fb_d = (len_entry ? 5'd0 : fb_q) + 5'd1;
                else begin
                  cl_d = {3'd0, (len_entry ? 5'd0 : fb_q)} + 8'd2;
                  lc_d = len_entry ? 2'd0 : fb_q[1:0];
                  ph_d = PH_RUN; fs_d = 2'd0; fc_d = 2'd0; fb_d = 5'd0; fv_d = 32'd0;
                end
              end else begin
                lc_d = 2'd3;
                if (bitv) begin
                  ph_d = PH_LENB; fs_d = 2'd0; fc_d = 2'd0; fb_d = 5'd0; fv_d = 32'd0;
                end else begin
                  ph_d = PH_LENX; fs_d = 2'd2; fb_d = 5'd3; fv_d = 32'd0;
                end
              end
            end else begin
              if (fs_q == 2'd0 && bitv) fs_d = 2'd1;
              else begin
                if (fs_q == 2'd2) begin
                  nval = {fv_q[30:0], bitv};
                  vdone = (fb_q <= 5'd1);
                  fb_d = (fb_q != 5'd0) ? fb_q - 5'd1 : 5'd0;
                  fv_d = nval;
                  ocls = fc_q;
                end else begin
                  ocls = (fs_q == 2'd0) ? 2'd0 : (bitv ? 2'd2 : 2'd1);
                  widx6 = {2'd0, ocls, 2'd0} + {4'd0, lc_q};
                  widx = widx6[3:0];
                  fwidth = (ph_q == PH_RUN) ? {1'b0, run_extra(widx)} :
                           5'(dbits_q >> (5 * widx));
                  fs_d = 2'd2; fc_d = ocls; fv_d = 32'd0; fb_d = fwidth;
                  vdone = (fwidth == 5'd0);
                  nval = 32'd0;
                end
                if (vdone) begin
                  fs_d = 2'd0; fc_d = 2'd0; fb_d = 5'd0; fv_d = 32'd0;
                  if (ph_q == PH_LENX) begin
                    cl_d = nval[7:0] + LEN_BIAS; ph_d = PH_RUN;
                  end else if (ph_q == PH_RUN) begin
                    lit_d = nval + ((ocls == 2'd0) ? 32'd0 : (ocls == 2'd1) ? 32'd2 :
                            {27'd0, run_far_base(lc_q)});
                    ph_d = PH_DIST;
                  end else begin
                    if (ocls == 2'd1) dbase = 16'(blo_q >> (16 * lc_q));
                    else if (ocls == 2'd2) dbase = 16'(bhi_q >> (16 * lc_q));
                    dsum = {1'b0, nval} + {17'd0, dbase};
                    dend = {1'b0, wp_q} + dsum;
                    if (dsum >= 33'(WINDOW_BYTES) || dend >= {1'b0, out_len_q}) ph_d = PH_ERR;
                    else begin
                      cd_d = dsum[19:0]; ph_d = PH_COPY;
                    end
                  end
                end
              end
            end
          end
        end
      end
      res_d.finished = (wp_d == 32'd0) && (ph_d != PH_ERR);
      res_d.distance_error = (ph_d == PH_ERR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q <= '0; first_q <= '0; seed_q <= 8'h80; skip_q <= 1'b0;
      blo_q <= '0; bhi_q <= '0; dbits_q <= '0;
      bb_q <= 8'h80; hb_q <= '0; hf_q <= 1'b0; pad_q <= 1'b0;
      wp_q <= '0; lit_q <= '0; cl_q <= '0; cd_q <= '0; lc_q <= '0; ph_q <= PH_LIT;
      fs_q <= '0; fc_q <= '0; fb_q <= '0; fv_q <= '0; res_q <= '0; copy_pend_q <= 1'b0;
    end else begin
      bb_q <= bb_d; hb_q <= hb_d; hf_q <= hf_d; pad_q <= pad_d;
      wp_q <= wp_d; lit_q <= lit_d; cl_q <= cl_d; cd_q <= cd_d; lc_q <= lc_d;
      ph_q <= ph_d; fs_q <= fs_d; fc_q <= fc_d; fb_q <= fb_d; fv_q <= fv_d;
      res_q <= res_d;
      copy_pend_q <= cmd_i.start && sts_o.need_read;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OUT_LEN: begin
            out_len_q <= cfg_data_i[31:0]; wp_q <= cfg_data_i[31:0]; ph_q <= PH_LIT;
            cl_q <= '0; cd_q <= '0; lc_q <= '0; hf_q <= 1'b0; hb_q <= '0;
            fs_q <= '0; fc_q <= '0; fb_q <= '0; fv_q <= '0;
          end
          REG_FIRST: begin
            first_q <= cfg_data_i[31:0]; lit_q <= cfg_data_i[31:0];
          end
          REG_SEED: begin
            seed_q <= cfg_data_i[7:0]; bb_q <= cfg_data_i[7:0];
          end
          REG_PAD: begin
            skip_q <= cfg_data_i[0]; pad_q <= cfg_data_i[0];
          end
          REG_BASE_LO: blo_q <= cfg_data_i;
          REG_BASE_HI: bhi_q <= cfg_data_i;
          REG_DBITS: dbits_q <= cfg_data_i[59:0];
          default: ;
        endcase
      end
    end
  end

  assign res_o = res_q;

`include "assert_macros.svh"
  `ASSERT_NEXT(a_copy_writes, clk_i, rst_ni, copy_pend_q && cmd_i.mem_wait, res_q.out_valid)
  `ASSERT_IMPL(a_err_not_fin, clk_i, rst_ni, ph_q == PH_ERR, ph_d == PH_ERR || cfg_we_i)
  `ASSERT_IMPL(a_wait_after_read, clk_i, rst_ni, cmd_i.mem_wait, copy_pend_q)
endmodule

[hw/rtl/lz_backward_decompressor_top.sv]
// Backward LZ decompressor. Each accepted word (deliver or advance) yields one
// result word. For deliver and most advance steps the result is offered the
// cycle after the accept, and the next word can be taken the cycle after the
// result is handed off. A match copy step passes through an extra read state
// for the registered history read. Output stalls hold the result until taken.
// Configure through APB while idle; a write to output_length restarts the decoder.
module lz_backward_decompressor_top import lzbd_pkg::*; #(
  parameter int WINDOW_BYTES = 131072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // compressed_byte
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_byte, out_position, zero fill
  output logic [5:0]  m_axis_tuser,   // out_valid, need_byte, byte_taken,
                                      // finished, distance_error, zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  ctl_cmd_t cmd;
  ctl_sts_t sts;
  result_t  res;
  logic     in_fire, out_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign pready = 1'b1;

  lzbd_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_fire_i(in_fire), .out_fire_i(out_fire),
    .sts_i(sts), .cmd_o(cmd), .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid)
  );

  lzbd_datapath #(.WINDOW_BYTES(WINDOW_BYTES)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .sts_o(sts),
    .cmd_bit_i(s_axis_tuser), .cbyte_i(s_axis_tdata),
    .cfg_we_i(psel && penable && pwrite), .cfg_idx_i(paddr[5:3]),
    .cfg_data_i(pwdata), .cfg_rdata_o(prdata), .res_o(res)
  );

  assign m_axis_tdata = {8'd0, res.out_position, res.out_byte};
  assign m_axis_tuser = {1'b0, res.distance_error, res.finished, res.byte_taken,
                         res.need_byte, res.out_valid};
endmodule
